>>> hw/rtl/rail_fence_transposer_assert.svh
// Assertion macros for the rail fence transposer.
// Expects aclk and aresetn in the scope of the module that uses them.
`ifndef RAIL_FENCE_TRANSPOSER_ASSERT_SVH
`define RAIL_FENCE_TRANSPOSER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RFT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rft: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define RFT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rft: next-cycle check failed");

`endif

>>> hw/rtl/rft_pkg.sv
// Shared types and constants for the rail fence transposer.
// No dependencies.
`timescale 1ns / 1ps

package rft_pkg;

    localparam int BYTE_W = 8;
    localparam int RAIL_W = 7;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
    } gen_cmd_t;

    typedef struct packed {
        logic active;
        logic last;
    } gen_sts_t;

endpackage

>>> hw/rtl/rft_order_gen.sv
// Read-address sequencer: walks stored positions rail by rail.
// Depends on rft_pkg.
`timescale 1ns / 1ps

module rft_order_gen #(
    parameter int MAX_LEN = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rft_pkg::gen_cmd_t                  cmd,
    input  logic [$clog2(MAX_LEN+1)-1:0]       len_in,
    input  logic [$clog2(MAX_LEN+1)-1:0]       rails_in,
    input  logic                               straight_in,
    output logic [$clog2(MAX_LEN)-1:0]         addr,
    output rft_pkg::gen_sts_t                  sts
);
    import rft_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int PW = CW + 2;

    logic          active_reg, active_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] r_reg, r_next;
    logic          phase_reg, phase_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] rails_reg, rails_next;
    logic          straight_reg, straight_next;
    logic [CW:0]   period_reg, period_next;

    logic          edge_rail;
    logic [CW:0]   two_r;
    logic [CW:0]   gap;
    logic [CW:0]   step_amt;
    logic [PW-1:0] p_sum;
    logic          in_range;
    logic          last;

    always_comb begin
        edge_rail = (r_reg == '0) || (r_reg == rails_reg - CW'(1));
        two_r     = {r_reg, 1'b0};
        gap       = period_reg - two_r;
        if (straight_reg) begin
            step_amt = (CW+1)'(1);
        end else if (edge_rail) begin
            step_amt = period_reg;
        end else if (phase_reg) begin
            step_amt = two_r;
        end else begin
            step_amt = gap;
        end
        p_sum    = PW'(p_reg) + PW'(step_amt);
        in_range = p_sum < PW'(len_reg);
        last     = (k_reg == len_reg - CW'(1));
    end

    always_comb begin
        active_next   = active_reg;
        p_next        = p_reg;
        r_next        = r_reg;
        phase_next    = phase_reg;
        k_next        = k_reg;
        len_next      = len_reg;
        rails_next    = rails_reg;
        straight_next = straight_reg;
        period_next   = period_reg;
        if (cmd.start) begin
            active_next   = 1'b1;
            p_next        = '0;
            r_next        = '0;
            phase_next    = 1'b0;
            k_next        = '0;
            len_next      = len_in;
            rails_next    = rails_in;
            straight_next = straight_in;
            period_next   = {rails_in, 1'b0} - (CW+1)'(2);
        end else if (cmd.step && active_reg) begin
            k_next = k_reg + CW'(1);
            if (last) begin
                active_next = 1'b0;
            end
            if (in_range) begin
                p_next     = p_sum[CW-1:0];
                phase_next = !phase_reg;
            end else begin
                r_next     = r_reg + CW'(1);
                p_next     = r_reg + CW'(1);
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            p_reg      <= '0;
            r_reg      <= '0;
            phase_reg  <= 1'b0;
            k_reg      <= '0;
        end else begin
            active_reg <= active_next;
            p_reg      <= p_next;
            r_reg      <= r_next;
            phase_reg  <= phase_next;
            k_reg      <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        rails_reg    <= rails_next;
        straight_reg <= straight_next;
        period_reg   <= period_next;
    end

    assign addr       = p_reg[AW-1:0];
    assign sts.active = active_reg;
    assign sts.last   = last;

endmodule

>>> hw/rtl/rail_fence_transposer.sv
// Rail fence transposer top level: message buffer, control and output register.
// Depends on rft_pkg, rft_order_gen and rail_fence_transposer_assert.svh.
//
// Usage:
//   Input requests (s_valid/s_ready) carry one message byte each; s_msg_end
//   marks the final byte. Bytes beyond MAX_LEN are dropped and flagged on
//   m_overflowed for every result of that message.
//   After the final byte, s_ready drops and the message is replayed rail by
//   rail on the result channel (m_valid/m_ready), m_out_end on the last byte.
//   After the final byte the sequencer starts, then reads the first result into
//   the output register. Throughput: one byte per cycle in, then one byte per
//   cycle out while the receiver keeps up; no byte can leave before the final
//   one is stored. s_ready returns the cycle after the last read, while the
//   final result may still wait in the output register. A stalled receiver holds
//   the output register; reads pause until it drains. cfg_we/cfg_wdata write the
//   rail count (reset 1); the user must write it only while the block is idle,
//   which the block does not enforce. Reset (aresetn, synchronous, active low)
//   empties the buffer and returns to loading; buffer contents are not cleared.
`timescale 1ns / 1ps

`include "rail_fence_transposer_assert.svh"

module rail_fence_transposer #(
    parameter int MAX_LEN = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [rft_pkg::RAIL_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [rft_pkg::BYTE_W-1:0] s_msg_byte,
    input  logic                       s_msg_end,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rft_pkg::BYTE_W-1:0] m_out_byte,
    output logic                       m_out_end,
    output logic                       m_overflowed
);
    import rft_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic                msg_ovf_reg, msg_ovf_next;
    logic [RAIL_W-1:0]   rails_reg;
    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_end_reg;
    logic                out_ovf_reg;

    logic [BYTE_W-1:0]   msg_mem [MAX_LEN];

    logic                accept;
    logic                full;
    logic [CW-1:0]       len_new;
    logic                straight;
    logic                issue;
    gen_cmd_t            gen_cmd;
    gen_sts_t            gen_sts;
    logic [AW-1:0]       rd_addr;

    assign s_ready = (state_reg == ST_LOAD);
    assign accept  = s_valid && s_ready;
    assign full    = (cnt_reg == CW'(MAX_LEN));
    assign len_new = full ? cnt_reg : cnt_reg + CW'(1);
    assign straight = (rails_reg <= RAIL_W'(1)) || (rails_reg >= RAIL_W'(len_new));
    assign issue   = gen_sts.active && (!m_valid_reg || m_ready);

    assign gen_cmd.start = accept && s_msg_end;
    assign gen_cmd.step  = issue;

    rft_order_gen #(
        .MAX_LEN (MAX_LEN)
    ) u_order_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (gen_cmd),
        .len_in      (len_new),
        .rails_in    (CW'(rails_reg)),
        .straight_in (straight),
        .addr        (rd_addr),
        .sts         (gen_sts)
    );

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        msg_ovf_next = msg_ovf_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (s_msg_end) begin
                        msg_ovf_next = ovf_reg || full;
                        ovf_next     = 1'b0;
                        cnt_next     = '0;
                        state_next   = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (issue && gen_sts.last) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (issue) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            msg_ovf_reg <= 1'b0;
            rails_reg   <= RAIL_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            msg_ovf_reg <= msg_ovf_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                rails_reg <= cfg_wdata;
            end
        end
    end

    // buffer write while loading
    always_ff @(posedge aclk) begin
        if (accept && !full) begin
            msg_mem[cnt_reg[AW-1:0]] <= s_msg_byte;
        end
    end

    // registered read doubles as the output register
    always_ff @(posedge aclk) begin
        if (issue) begin
            out_byte_reg <= msg_mem[rd_addr];
            out_end_reg  <= gen_sts.last;
            out_ovf_reg  <= msg_ovf_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_out_end    = out_end_reg;
    assign m_overflowed = out_ovf_reg;

    `RFT_ASSERT_SAME(a_no_load_while_emit, gen_sts.active, !s_ready)
    `RFT_ASSERT_NEXT(a_end_starts_emit, accept && s_msg_end,
                     state_reg == ST_EMIT && gen_sts.active)
    `RFT_ASSERT_NEXT(a_full_end_flags_ovf, accept && s_msg_end && full, msg_ovf_reg)

endmodule
